@@ design/fas_pkg.sv @@
// ============================================================================
// fas_pkg
// Shared types, codes and helpers for the frame animation sequencer.
// ============================================================================
package fas_pkg;

    localparam int IDX_W      = 6;
    localparam int TV_W       = 24;
    localparam int MODE_W     = 3;
    localparam int ERR_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int WHOLE_W    = 32;

    // Input mode codes.
    localparam logic [MODE_W-1:0] MODE_TICK    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_WRITE   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FILL    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SEEK    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RESTART = 3'd4;

    // Result error codes.
    localparam logic [ERR_W-1:0] ERR_OK       = 2'd0;
    localparam logic [ERR_W-1:0] ERR_INDEX    = 2'd1;
    localparam logic [ERR_W-1:0] ERR_DURATION = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PLAY_ENABLE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_WAIT   = 3'd4;

    typedef enum logic [2:0] {
        OP_TICK,
        OP_WRITE,
        OP_FILL,
        OP_SEEK,
        OP_RESTART,
        OP_NONE
    } t_op;

    // A classified command word as it travels through the queue.
    typedef struct packed {
        t_op               op;
        logic [IDX_W-1:0]  idx;
        logic [TV_W-1:0]   tv;
        logic              wreq;
        logic              idx_bad;
        logic              tv_zero;
    } t_cmd;

    // Mask of the low time bits kept from a time value.
    function automatic logic [TV_W-1:0] time_mask(input int bits);
        logic [63:0] m;
        m = (64'd1 << bits) - 64'd1;
        return TV_W'(m);
    endfunction

endpackage

@@ design/frame_animation_sequencer.sv @@
// ============================================================================
// frame_animation_sequencer
// Sprite frame timer: per-frame duration table, forward/reverse play, loops.
// ============================================================================
//
//  channel   direction  handshake                     word
//  command   in         start, busy                   mode, frame_index, time_value,
//                                                     wait_after_restart
//  config    in         i_cfg_valid, o_cfg_ready      i_cfg_index, i_cfg_data
//  result    out        o_strobe (one cycle)          frame .. error
//
//  Every command word gives one result word. A write or a reverse restart waits for a
//  registered table read; a seek reads and sums the table durations frame by frame; a
//  tick steps through the frames, and each fold of whole loops goes through the divider.
//  A two-word queue feeds the engine; busy is high while it is full. The receiver cannot
//  stall. Reset is synchronous; no clearing pass is needed.
//
module frame_animation_sequencer #(
    parameter int MAX_FRAMES       = 64,
    parameter int TIME_BITS        = 24,
    parameter int DEFAULT_DURATION = 100,
    parameter int LOOP_COUNT_BITS  = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [fas_pkg::MODE_W-1:0]        i_mode,
    input  logic [fas_pkg::IDX_W-1:0]         i_frame_index,
    input  logic [fas_pkg::TV_W-1:0]          i_time_value,
    input  logic                              i_wait_after_restart,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [fas_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [fas_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                              o_strobe,
    output logic [fas_pkg::IDX_W-1:0]         o_frame,
    output logic                              o_finished,
    output logic                              o_waiting,
    output logic [LOOP_COUNT_BITS-1:0]        o_loops_done,
    output logic [fas_pkg::WHOLE_W-1:0]       o_elapsed,
    output logic [fas_pkg::ERR_W-1:0]         o_error
);

    localparam int CW = $clog2(MAX_FRAMES + 1);

    fas_pkg::t_cmd w_push_cmd;
    fas_pkg::t_cmd w_pop_cmd;
    logic          w_push;
    logic          w_pop;
    logic          w_full;
    logic          w_empty;
    logic [CW-1:0] w_fc;

    assign o_cfg_ready = 1'b1;

    fas_front #(
        .TIME_BITS (TIME_BITS),
        .CW        (CW)
    ) u_front (
        .i_start              (start),
        .i_mode               (i_mode),
        .i_frame_index        (i_frame_index),
        .i_time_value         (i_time_value),
        .i_wait_after_restart (i_wait_after_restart),
        .i_full               (w_full),
        .i_fc                 (w_fc),
        .o_busy               (busy),
        .o_push               (w_push),
        .o_cmd                (w_push_cmd)
    );

    fas_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_cmd),
        .i_pop   (w_pop),
        .o_data  (w_pop_cmd),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    fas_back #(
        .MAX_FRAMES       (MAX_FRAMES),
        .TIME_BITS        (TIME_BITS),
        .DEFAULT_DURATION (DEFAULT_DURATION),
        .LOOP_COUNT_BITS  (LOOP_COUNT_BITS),
        .CW               (CW)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_pop_cmd),
        .i_empty      (w_empty),
        .o_pop        (w_pop),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fc         (w_fc),
        .o_strobe     (o_strobe),
        .o_frame      (o_frame),
        .o_finished   (o_finished),
        .o_waiting    (o_waiting),
        .o_loops_done (o_loops_done),
        .o_elapsed    (o_elapsed),
        .o_error      (o_error)
    );

    // The engine returns to idle after every result, so results never come back to back.
    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("two results in consecutive cycles");

    // The reported frame always lies inside the frames in use.
    a_frame_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (32'(o_frame) < 32'(w_fc)))
        else $error("frame beyond frame count");

    // A finished animation is never also holding in the loop wait.
    a_fin_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !(o_finished && o_waiting))
        else $error("finished and waiting together");

endmodule

@@ design/fas_ram.sv @@
// ============================================================================
// fas_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module fas_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/fas_div.sv @@
// ============================================================================
// fas_div
// Restoring divider, one quotient bit per cycle.
// ============================================================================
module fas_div #(
    parameter int DW = 27,
    parameter int VW = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quot,
    output logic [DW-1:0] o_rem
);

    localparam int CMPW = ((DW + 1) > VW) ? (DW + 1) : VW;
    localparam int NW   = $clog2(DW + 1);

    logic [DW-1:0] r_dvd;
    logic [VW-1:0] r_dvs;
    logic [DW-1:0] r_quot;
    logic [DW-1:0] r_rem;
    logic [NW-1:0] r_cnt;
    logic          r_run;
    logic          r_done;

    logic [DW:0]   w_sh;
    logic          w_ge;
    logic [CMPW-1:0] w_diff;

    assign w_sh   = {r_rem, r_dvd[DW-1]};
    assign w_ge   = CMPW'(w_sh) >= CMPW'(r_dvs);
    assign w_diff = CMPW'(w_sh) - CMPW'(r_dvs);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_dvd  <= i_dividend;
                r_dvs  <= i_divisor;
                r_rem  <= '0;
                r_quot <= '0;
                r_cnt  <= NW'(DW);
                r_run  <= 1'b1;
            end else if (r_run) begin
                r_dvd  <= {r_dvd[DW-2:0], 1'b0};
                r_quot <= {r_quot[DW-2:0], w_ge};
                // The partial remainder never outgrows the bits already shifted in.
                r_rem  <= w_ge ? DW'(w_diff) : w_sh[DW-1:0];
                r_cnt  <= r_cnt - NW'(1);
                if (r_cnt == NW'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

@@ design/fas_fifo.sv @@
// ============================================================================
// fas_fifo
// Two-entry command queue between the front and the back.
// ============================================================================
module fas_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  fas_pkg::t_cmd i_data,
    input  logic          i_pop,
    output fas_pkg::t_cmd o_data,
    output logic          o_full,
    output logic          o_empty
);

    fas_pkg::t_cmd r_ent [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_ent[r_wp] <= i_data;
                r_wp        <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    assign o_data  = r_ent[r_rp];
    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);

endmodule

@@ design/fas_front.sv @@
// ============================================================================
// fas_front
// Accepts command words and classifies them before they enter the queue.
// ============================================================================
module fas_front #(
    parameter int TIME_BITS = 24,
    parameter int CW        = 7
) (
    input  logic                          i_start,
    input  logic [fas_pkg::MODE_W-1:0]    i_mode,
    input  logic [fas_pkg::IDX_W-1:0]     i_frame_index,
    input  logic [fas_pkg::TV_W-1:0]      i_time_value,
    input  logic                          i_wait_after_restart,
    input  logic                          i_full,
    input  logic [CW-1:0]                 i_fc,
    output logic                          o_busy,
    output logic                          o_push,
    output fas_pkg::t_cmd                 o_cmd
);

    logic [fas_pkg::TV_W-1:0] w_tv;

    assign w_tv = i_time_value & fas_pkg::time_mask(TIME_BITS);

    always_comb begin
        case (i_mode)
            fas_pkg::MODE_TICK:    o_cmd.op = fas_pkg::OP_TICK;
            fas_pkg::MODE_WRITE:   o_cmd.op = fas_pkg::OP_WRITE;
            fas_pkg::MODE_FILL:    o_cmd.op = fas_pkg::OP_FILL;
            fas_pkg::MODE_SEEK:    o_cmd.op = fas_pkg::OP_SEEK;
            fas_pkg::MODE_RESTART: o_cmd.op = fas_pkg::OP_RESTART;
            default:               o_cmd.op = fas_pkg::OP_NONE;
        endcase
        o_cmd.idx     = i_frame_index;
        o_cmd.tv      = w_tv;
        o_cmd.wreq    = i_wait_after_restart;
        o_cmd.idx_bad = 32'(i_frame_index) >= 32'(i_fc);
        o_cmd.tv_zero = (w_tv == '0);
    end

    assign o_busy = i_full;
    assign o_push = i_start && !i_full;

endmodule

@@ design/fas_back.sv @@
// ============================================================================
// fas_back
// Carries out queued commands: duration table, play position and loop logic.
// ============================================================================
module fas_back #(
    parameter int MAX_FRAMES       = 64,
    parameter int TIME_BITS        = 24,
    parameter int DEFAULT_DURATION = 100,
    parameter int LOOP_COUNT_BITS  = 16,
    parameter int CW               = 7
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  fas_pkg::t_cmd                     i_cmd,
    input  logic                              i_empty,
    output logic                              o_pop,
    input  logic                              i_cfg_valid,
    input  logic [fas_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [fas_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic [CW-1:0]                     o_fc,
    output logic                              o_strobe,
    output logic [fas_pkg::IDX_W-1:0]         o_frame,
    output logic                              o_finished,
    output logic                              o_waiting,
    output logic [LOOP_COUNT_BITS-1:0]        o_loops_done,
    output logic [fas_pkg::WHOLE_W-1:0]       o_elapsed,
    output logic [fas_pkg::ERR_W-1:0]         o_error
);

    localparam int FW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int TW = fas_pkg::TV_W;
    localparam int DW = 27;
    localparam logic [TW-1:0] DEF_DUR =
        TW'(DEFAULT_DURATION) & fas_pkg::time_mask(TIME_BITS);
    localparam logic [33:0] LOOP_MAX = (34'd1 << LOOP_COUNT_BITS) - 34'd1;

    typedef enum logic [4:0] {
        S_IDLE, S_EXEC, S_RD, S_HOLD_REV, S_WR_USE, S_SEEK, S_SEEK_ADD, S_RST_USE,
        S_F_TOP, S_F_DIV, S_F_CHK, S_F_END, S_R_TOP, S_R_SC, S_R_DIV, S_R_BRK,
        S_R_ADD, S_OUT
    } t_state;

    function automatic logic [LOOP_COUNT_BITS-1:0] sat_add(
        input logic [LOOP_COUNT_BITS-1:0] a,
        input logic [DW-1:0]              k
    );
        logic [33:0] s;
        s = 34'(a) + 34'(k);
        if (s > LOOP_MAX) begin
            return LOOP_COUNT_BITS'(LOOP_MAX);
        end
        return LOOP_COUNT_BITS'(s);
    endfunction

    t_state                      r_state;
    t_state                      r_ret;
    fas_pkg::t_cmd               r_cmd;

    logic [CW-1:0]               r_fc;
    logic                        r_rev;
    logic                        r_le;
    logic                        r_pe;
    logic [TW-1:0]               r_lw;

    logic [MAX_FRAMES-1:0]       r_valid;
    logic [TW-1:0]               r_fill;
    logic                        r_vld_q;
    logic [FW-1:0]               r_ra;

    logic [FW-1:0]               r_cur;
    logic signed [DW-1:0]        r_ft;
    logic [31:0]                 r_whole;
    logic [31:0]                 r_total;
    logic [24:0]                 r_wt;
    logic [LOOP_COUNT_BITS-1:0]  r_loops;
    logic                        r_done;
    logic                        r_wait;
    logic [fas_pkg::ERR_W-1:0]   r_err;

    logic [25:0]                 r_ex;
    logic [TW-1:0]               r_dlast;
    logic [CW-1:0]               r_i;
    logic [CW-1:0]               r_n;
    logic [31:0]                 r_sum;

    logic                        r_div_start;
    logic [DW-1:0]               r_dvd;
    logic [31:0]                 r_dvs;

    logic                        r_strobe;
    logic [fas_pkg::IDX_W-1:0]   r_o_frame;
    logic                        r_o_fin;
    logic                        r_o_wait;
    logic [LOOP_COUNT_BITS-1:0]  r_o_loops;
    logic [31:0]                 r_o_whole;
    logic [fas_pkg::ERR_W-1:0]   r_o_err;

    logic [TW-1:0]               w_ram_q;
    logic [TW-1:0]               w_dur;
    logic signed [DW-1:0]        w_dur_s;
    logic signed [DW-1:0]        w_tv_s;
    logic signed [DW-1:0]        w_lw_s;
    logic [31:0]                 w_c;
    logic [FW-1:0]               w_last;
    logic                        w_ft_ge_c;
    logic signed [27:0]          w_def;
    logic                        w_def_ge_c;
    logic signed [DW-1:0]        w_ft_sub;
    logic signed [DW-1:0]        w_ft_add;
    logic signed [DW-1:0]        w_over;
    logic [25:0]                 w_wsum;
    logic [25:0]                 w_excess;
    logic [FW-1:0]               w_nxt;
    logic [31:0]                 w_sat_fc;
    logic                        w_div_done;
    logic [DW-1:0]               w_quot;
    logic [DW-1:0]               w_rem;

    // A table entry not written since the last fill reads as the fill value.
    assign w_dur      = r_vld_q ? w_ram_q : r_fill;
    assign w_dur_s    = $signed(DW'(w_dur));
    assign w_tv_s     = $signed(DW'(r_cmd.tv));
    assign w_lw_s     = $signed(DW'(r_lw));
    assign w_c        = r_total + 32'(r_lw);
    assign w_last     = FW'(r_fc - CW'(1));
    assign w_ft_ge_c  = !r_ft[DW-1] && (32'(unsigned'(r_ft)) >= w_c);
    assign w_def      = 28'(w_dur_s) - 28'(r_ft);
    assign w_def_ge_c = !w_def[27] && (32'(unsigned'(w_def)) >= w_c);
    assign w_ft_sub   = r_ft - w_dur_s;
    assign w_ft_add   = r_ft + w_dur_s;
    assign w_over     = -r_ft;
    assign w_wsum     = 26'(r_wt) + 26'(r_cmd.tv);
    assign w_excess   = w_wsum - 26'(r_lw);
    assign w_nxt      = (32'(r_cur) + 32'd1 >= 32'(r_fc)) ? '0 : FW'(r_cur + FW'(1));

    always_comb begin
        w_sat_fc = 32'(i_cfg_data[6:0]);
        if (w_sat_fc < 32'd1) begin
            w_sat_fc = 32'd1;
        end
        if (w_sat_fc > 32'(MAX_FRAMES)) begin
            w_sat_fc = 32'(MAX_FRAMES);
        end
    end

    fas_ram #(
        .WIDTH (TW),
        .DEPTH (MAX_FRAMES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == S_WR_USE),
        .i_waddr (r_ra),
        .i_wdata (r_cmd.tv),
        .i_raddr (r_ra),
        .o_rdata (w_ram_q)
    );

    fas_div #(
        .DW (DW),
        .VW (32)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_dvd),
        .i_divisor  (r_dvs),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    assign o_pop = (r_state == S_IDLE) && !i_empty;

    always_ff @(posedge i_clk) begin
        r_vld_q <= r_valid[r_ra];
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ret       <= S_IDLE;
            r_fc        <= CW'(1);
            r_rev       <= 1'b0;
            r_le        <= 1'b1;
            r_pe        <= 1'b1;
            r_lw        <= '0;
            r_valid     <= '0;
            r_fill      <= DEF_DUR;
            r_ra        <= '0;
            r_cur       <= '0;
            r_ft        <= '0;
            r_whole     <= '0;
            r_total     <= 32'(DEF_DUR);
            r_wt        <= '0;
            r_loops     <= '0;
            r_done      <= 1'b0;
            r_wait      <= 1'b0;
            r_err       <= fas_pkg::ERR_OK;
            r_div_start <= 1'b0;
            r_strobe    <= 1'b0;
        end else begin
            r_strobe    <= 1'b0;
            r_div_start <= 1'b0;

            if (i_cfg_valid) begin
                case (i_cfg_index)
                    fas_pkg::CFG_FRAME_COUNT: begin
                        r_fc    <= CW'(w_sat_fc);
                        r_valid <= '0;
                        r_fill  <= DEF_DUR;
                        r_total <= 32'(w_sat_fc * 32'(DEF_DUR));
                        if (32'(r_cur) >= w_sat_fc) begin
                            r_cur <= FW'(w_sat_fc - 32'd1);
                        end
                    end
                    fas_pkg::CFG_REVERSE: begin
                        if (i_cfg_data[0] != r_rev) begin
                            r_loops <= '0;
                            r_done  <= 1'b0;
                        end
                        r_rev <= i_cfg_data[0];
                    end
                    fas_pkg::CFG_LOOP_ENABLE: begin
                        r_le <= i_cfg_data[0];
                        if (i_cfg_data[0]) begin
                            r_done <= 1'b0;
                        end
                    end
                    fas_pkg::CFG_PLAY_ENABLE: begin
                        r_pe <= i_cfg_data[0];
                        if (!i_cfg_data[0]) begin
                            r_loops <= '0;
                        end
                    end
                    fas_pkg::CFG_LOOP_WAIT: begin
                        r_lw <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_cmd   <= i_cmd;
                        r_state <= S_EXEC;
                    end
                end

                S_EXEC: begin
                    r_err   <= fas_pkg::ERR_OK;
                    r_state <= S_OUT;
                    case (r_cmd.op)
                        fas_pkg::OP_TICK: begin
                            if (r_pe && !r_done) begin
                                if (r_wait) begin
                                    if (w_wsum < 26'(r_lw)) begin
                                        r_wt <= w_wsum[24:0];
                                    end else begin
                                        r_wait <= 1'b0;
                                        r_wt   <= '0;
                                        if (!r_rev) begin
                                            r_ft    <= $signed(DW'(w_excess));
                                            r_whole <= 32'(w_excess);
                                        end else begin
                                            r_ex    <= w_excess;
                                            r_ra    <= r_cur;
                                            r_ret   <= S_HOLD_REV;
                                            r_state <= S_RD;
                                        end
                                    end
                                end else if (!r_rev) begin
                                    r_ft    <= r_ft + w_tv_s;
                                    r_whole <= r_whole + 32'(r_cmd.tv);
                                    r_state <= S_F_TOP;
                                end else begin
                                    r_ft    <= r_ft - w_tv_s;
                                    r_whole <= r_whole - 32'(r_cmd.tv);
                                    r_state <= S_R_TOP;
                                end
                            end
                        end
                        fas_pkg::OP_WRITE: begin
                            if (r_cmd.idx_bad) begin
                                r_err <= fas_pkg::ERR_INDEX;
                            end else if (r_cmd.tv_zero) begin
                                r_err <= fas_pkg::ERR_DURATION;
                            end else begin
                                r_ra    <= FW'(r_cmd.idx);
                                r_ret   <= S_WR_USE;
                                r_state <= S_RD;
                            end
                        end
                        fas_pkg::OP_FILL: begin
                            if (r_cmd.tv_zero) begin
                                r_err <= fas_pkg::ERR_DURATION;
                            end else begin
                                r_valid <= '0;
                                r_fill  <= r_cmd.tv;
                                r_total <= 32'(r_cmd.tv) * 32'(r_fc);
                            end
                        end
                        fas_pkg::OP_SEEK: begin
                            if (r_cmd.idx_bad) begin
                                r_err <= fas_pkg::ERR_INDEX;
                            end else begin
                                r_n     <= CW'(r_cmd.idx) + CW'(r_rev);
                                r_i     <= '0;
                                r_sum   <= '0;
                                r_state <= S_SEEK;
                            end
                        end
                        fas_pkg::OP_RESTART: begin
                            r_wait <= r_cmd.wreq;
                            r_done <= 1'b0;
                            if (!r_rev) begin
                                r_cur   <= '0;
                                r_ft    <= '0;
                                r_whole <= '0;
                            end else begin
                                r_cur   <= w_last;
                                r_ra    <= w_last;
                                r_ret   <= S_RST_USE;
                                r_state <= S_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end

                // Wait state for the registered table read.
                S_RD: begin
                    r_state <= r_ret;
                end

                S_HOLD_REV: begin
                    r_ft    <= w_dur_s - $signed(DW'(r_ex));
                    r_whole <= r_total - 32'(r_ex);
                    r_state <= S_OUT;
                end

                S_WR_USE: begin
                    r_total     <= r_total - 32'(w_dur) + 32'(r_cmd.tv);
                    r_valid[r_ra] <= 1'b1;
                    r_state     <= S_OUT;
                end

                S_SEEK: begin
                    if (r_i < r_n) begin
                        r_ra    <= FW'(r_i);
                        r_ret   <= S_SEEK_ADD;
                        r_state <= S_RD;
                    end else begin
                        r_cur   <= FW'(r_cmd.idx);
                        r_done  <= 1'b0;
                        r_whole <= r_sum;
                        r_state <= S_OUT;
                    end
                end

                S_SEEK_ADD: begin
                    r_sum   <= r_sum + 32'(w_dur);
                    r_i     <= r_i + CW'(1);
                    r_state <= S_SEEK;
                end

                S_RST_USE: begin
                    r_ft    <= w_dur_s;
                    r_whole <= r_total;
                    r_state <= S_OUT;
                end

                // Forward play: whole loops at frame zero go through the divider.
                S_F_TOP: begin
                    if ((r_cur == '0) && r_le && w_ft_ge_c) begin
                        r_dvd       <= DW'(unsigned'(r_ft));
                        r_dvs       <= w_c;
                        r_div_start <= 1'b1;
                        r_state     <= S_F_DIV;
                    end else begin
                        r_ra    <= r_cur;
                        r_ret   <= S_F_CHK;
                        r_state <= S_RD;
                    end
                end

                S_F_DIV: begin
                    if (w_div_done) begin
                        r_ft    <= $signed(w_rem);
                        r_whole <= 32'(w_rem);
                        r_loops <= sat_add(r_loops, w_quot);
                        r_ra    <= r_cur;
                        r_ret   <= S_F_CHK;
                        r_state <= S_RD;
                    end
                end

                S_F_CHK: begin
                    if (r_ft < w_dur_s) begin
                        r_state <= S_OUT;
                    end else begin
                        r_ft    <= w_ft_sub;
                        r_cur   <= w_nxt;
                        r_state <= S_F_TOP;
                        if (w_nxt == '0) begin
                            if (r_le) begin
                                r_loops <= sat_add(r_loops, DW'(1));
                                r_whole <= 32'(w_ft_sub);
                                if (r_lw != '0) begin
                                    if (w_ft_sub < w_lw_s) begin
                                        r_wt    <= w_ft_sub[24:0];
                                        r_ft    <= '0;
                                        r_whole <= '0;
                                        r_wait  <= 1'b1;
                                        r_state <= S_OUT;
                                    end else begin
                                        r_ft    <= w_ft_sub - w_lw_s;
                                        r_whole <= 32'(w_ft_sub) - 32'(r_lw);
                                        r_wt    <= '0;
                                    end
                                end
                            end else begin
                                r_cur   <= w_last;
                                r_ra    <= w_last;
                                r_ret   <= S_F_END;
                                r_state <= S_RD;
                            end
                        end
                    end
                end

                S_F_END: begin
                    r_ft    <= w_dur_s;
                    r_whole <= r_total;
                    r_done  <= 1'b1;
                    r_state <= S_OUT;
                end

                // Reverse play: whole loops at the last frame go through the divider.
                S_R_TOP: begin
                    if ((r_cur == w_last) && r_le) begin
                        r_ra    <= w_last;
                        r_ret   <= S_R_SC;
                        r_state <= S_RD;
                    end else begin
                        r_state <= S_R_BRK;
                    end
                end

                S_R_SC: begin
                    r_state <= S_R_BRK;
                    if (w_def_ge_c) begin
                        r_dvd       <= DW'(unsigned'(w_def));
                        r_dvs       <= w_c;
                        r_dlast     <= w_dur;
                        r_div_start <= 1'b1;
                        r_state     <= S_R_DIV;
                    end
                end

                S_R_DIV: begin
                    if (w_div_done) begin
                        r_ft    <= $signed(DW'(r_dlast)) - $signed(w_rem);
                        r_whole <= r_total - 32'(w_rem);
                        r_loops <= sat_add(r_loops, w_quot);
                        r_state <= S_R_BRK;
                    end
                end

                S_R_BRK: begin
                    if (r_ft > $signed(DW'(0))) begin
                        r_state <= S_OUT;
                    end else begin
                        r_cur   <= (r_cur == '0) ? w_last : FW'(r_cur - FW'(1));
                        r_ra    <= (r_cur == '0) ? w_last : FW'(r_cur - FW'(1));
                        r_ret   <= S_R_ADD;
                        r_state <= S_RD;
                    end
                end

                // Here r_ft still holds the time before the step back.
                S_R_ADD: begin
                    r_ft    <= w_ft_add;
                    r_state <= S_R_TOP;
                    if (r_cur == w_last) begin
                        if (r_le) begin
                            r_loops <= sat_add(r_loops, DW'(1));
                            r_whole <= r_total + 32'(r_ft);
                            if (r_lw != '0) begin
                                if (w_over < w_lw_s) begin
                                    r_wt    <= w_over[24:0];
                                    r_ft    <= w_dur_s;
                                    r_whole <= r_total;
                                    r_wait  <= 1'b1;
                                    r_state <= S_OUT;
                                end else begin
                                    r_ft    <= w_ft_add + w_lw_s;
                                    r_whole <= r_total + 32'(r_ft) + 32'(r_lw);
                                    r_wt    <= '0;
                                end
                            end
                        end else begin
                            r_cur   <= '0;
                            r_ft    <= '0;
                            r_whole <= '0;
                            r_done  <= 1'b1;
                            r_state <= S_OUT;
                        end
                    end
                end

                S_OUT: begin
                    r_strobe  <= 1'b1;
                    r_o_frame <= fas_pkg::IDX_W'(r_cur);
                    r_o_fin   <= r_done;
                    r_o_wait  <= r_wait;
                    r_o_loops <= r_loops;
                    r_o_whole <= r_whole;
                    r_o_err   <= r_err;
                    r_state   <= S_IDLE;
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_fc         = r_fc;
    assign o_strobe     = r_strobe;
    assign o_frame      = r_o_frame;
    assign o_finished   = r_o_fin;
    assign o_waiting    = r_o_wait;
    assign o_loops_done = r_o_loops;
    assign o_elapsed    = r_o_whole;
    assign o_error      = r_o_err;

endmodule

@@ tb/tb_frame_animation_sequencer.sv @@
// ============================================================================
// tb_frame_animation_sequencer
// Self-checking bench for the frame animation sequencer. A behavioral copy of
// the sequencer predicts the status word for every accepted command word, and
// a monitor compares each strobed status word with the oldest prediction.
// ============================================================================
module tb_frame_animation_sequencer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     NFRAMES  = 64;
    localparam longint DEF_DUR  = 100;
    localparam longint LOOP_MAX = 65535;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           start = 1'b0;
    logic                           busy;
    logic [fas_pkg::MODE_W-1:0]     i_mode = fas_pkg::MODE_TICK;
    logic [fas_pkg::IDX_W-1:0]      i_frame_index = '0;
    logic [fas_pkg::TV_W-1:0]       i_time_value = '0;
    logic                           i_wait_after_restart = 1'b0;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [fas_pkg::CFG_IDX_W-1:0]  i_cfg_index = fas_pkg::CFG_FRAME_COUNT;
    logic [fas_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                           o_strobe;
    logic [fas_pkg::IDX_W-1:0]      o_frame;
    logic                           o_finished;
    logic                           o_waiting;
    logic [15:0]                    o_loops_done;
    logic [fas_pkg::WHOLE_W-1:0]    o_elapsed;
    logic [fas_pkg::ERR_W-1:0]      o_error;

    frame_animation_sequencer DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_mode(i_mode), .i_frame_index(i_frame_index), .i_time_value(i_time_value),
        .i_wait_after_restart(i_wait_after_restart),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_strobe(o_strobe), .o_frame(o_frame), .o_finished(o_finished),
        .o_waiting(o_waiting), .o_loops_done(o_loops_done), .o_elapsed(o_elapsed),
        .o_error(o_error)
    );

    always #10 i_clk = ~i_clk;

    typedef struct {
        logic [fas_pkg::IDX_W-1:0]   frame;
        logic                        finished;
        logic                        waiting;
        logic [15:0]                 loops;
        logic [fas_pkg::WHOLE_W-1:0] elapsed;
        logic [fas_pkg::ERR_W-1:0]   err;
    } t_status;

    t_status expected_status_q[$];
    int      fail_count = 0;
    bit      idle_on = 1'b1;

    // Sequencer state mirror.
    longint      dur[NFRAMES];
    int          fc;
    bit          rev, loop_en, play_en;
    longint      lw;
    int          cf;
    longint      ft;
    logic [31:0] wt;
    longint      tot;
    longint      wait_t;
    longint      lc;
    bit          done, wst;

    function automatic void fill_durations(longint d);
        for (int i = 0; i < NFRAMES; i++) dur[i] = d;
        tot = d * fc;
    endfunction

    function automatic void count_loops(longint k);
        if (k >= LOOP_MAX - lc) lc = LOOP_MAX;
        else lc = lc + k;
    endfunction

    function automatic void reset_sequencer();
        fc = 1; rev = 0; loop_en = 1; play_en = 1; lw = 0;
        fill_durations(DEF_DUR);
        cf = 0; ft = 0; wt = '0; wait_t = 0; lc = 0; done = 0; wst = 0;
    endfunction

    function automatic void play_forward(longint delta);
        longint c, k;
        ft = ft + delta;
        wt = wt + 32'(delta);
        while (1) begin
            if (cf == 0 && loop_en) begin
                c = tot + lw;
                if (ft >= c) begin
                    k = ft / c;
                    ft = ft - k * c;
                    count_loops(k);
                    wt = 32'(ft);
                end
            end
            if (ft < dur[cf]) break;
            ft = ft - dur[cf];
            cf++;
            if (cf >= fc) cf = 0;
            if (cf != 0) continue;
            if (loop_en) begin
                count_loops(1);
                wt = 32'(ft);
                if (lw == 0) continue;
                if (ft < lw) begin
                    wait_t = ft; ft = 0; wt = '0; wst = 1;
                    break;
                end
                ft = ft - lw;
                wt = wt - 32'(lw);
                wait_t = 0;
            end else begin
                cf = fc - 1; ft = dur[cf]; wt = 32'(tot); done = 1;
                break;
            end
        end
    endfunction

    function automatic void play_backward(longint delta);
        int     last;
        longint c, k, deficit, prior;
        last = fc - 1;
        ft = ft - delta;
        wt = wt - 32'(delta);
        while (1) begin
            if (cf == last && loop_en) begin
                c = tot + lw;
                deficit = dur[last] - ft;
                if (deficit >= c) begin
                    k = deficit / c;
                    ft = ft + k * c;
                    count_loops(k);
                    wt = 32'(tot + ft - dur[last]);
                end
            end
            if (ft > 0) break;
            prior = ft;
            cf = (cf == 0) ? last : cf - 1;
            ft = ft + dur[cf];
            if (cf != last) continue;
            if (loop_en) begin
                count_loops(1);
                wt = 32'(tot + prior);
                if (lw == 0) continue;
                if (-prior < lw) begin
                    wait_t = -prior; ft = dur[last]; wt = 32'(tot); wst = 1;
                    break;
                end
                ft = ft + lw;
                wt = wt + 32'(lw);
                wait_t = 0;
            end else begin
                cf = 0; ft = 0; wt = '0; done = 1;
                break;
            end
        end
    endfunction

    function automatic void hold_tick(longint delta);
        longint excess;
        wait_t = (wait_t + delta) & 64'hFFFF_FFFF;
        if (wait_t < lw) return;
        wst = 0;
        excess = wait_t - lw;
        if (!rev) begin
            ft = excess; wt = 32'(excess);
        end else begin
            ft = dur[cf] - excess; wt = 32'(tot - excess);
        end
        wait_t = 0;
    endfunction

    function automatic void apply_register(logic [fas_pkg::CFG_IDX_W-1:0] idx,
                                           logic [fas_pkg::CFG_DATA_W-1:0] data);
        int v;
        case (idx)
            fas_pkg::CFG_FRAME_COUNT: begin
                v = int'(data[6:0]);
                if (v < 1) v = 1;
                if (v > NFRAMES) v = NFRAMES;
                fc = v;
                fill_durations(DEF_DUR);
                if (cf >= fc) cf = fc - 1;
            end
            fas_pkg::CFG_REVERSE: begin
                if (data[0] != rev) begin
                    lc = 0; done = 0;
                end
                rev = data[0];
            end
            fas_pkg::CFG_LOOP_ENABLE: begin
                loop_en = data[0];
                if (loop_en) done = 0;
            end
            fas_pkg::CFG_PLAY_ENABLE: begin
                play_en = data[0];
                if (!play_en) lc = 0;
            end
            fas_pkg::CFG_LOOP_WAIT: lw = longint'(data);
            default: ;
        endcase
    endfunction

    function automatic t_status advance_sequencer(logic [fas_pkg::MODE_W-1:0] mode,
                                                  logic [fas_pkg::IDX_W-1:0] idx,
                                                  logic [fas_pkg::TV_W-1:0] tv,
                                                  logic wreq);
        t_status     s;
        logic [31:0] sum;
        longint      tvl;
        s.err = fas_pkg::ERR_OK;
        tvl = longint'(tv);
        case (mode)
            fas_pkg::MODE_TICK: begin
                if (play_en && !done) begin
                    if (wst) hold_tick(tvl);
                    else if (!rev) play_forward(tvl);
                    else play_backward(tvl);
                end
            end
            fas_pkg::MODE_WRITE: begin
                if (idx >= fc) s.err = fas_pkg::ERR_INDEX;
                else if (tvl == 0) s.err = fas_pkg::ERR_DURATION;
                else begin
                    tot = tot - dur[idx] + tvl;
                    dur[idx] = tvl;
                end
            end
            fas_pkg::MODE_FILL: begin
                if (tvl == 0) s.err = fas_pkg::ERR_DURATION;
                else fill_durations(tvl);
            end
            fas_pkg::MODE_SEEK: begin
                if (idx >= fc) s.err = fas_pkg::ERR_INDEX;
                else begin
                    sum = '0;
                    for (int i = 0; i < int'(idx) + (rev ? 1 : 0); i++) sum += 32'(dur[i]);
                    cf = idx; done = 0; wt = sum;
                end
            end
            fas_pkg::MODE_RESTART: begin
                wst = wreq;
                done = 0;
                if (!rev) begin
                    cf = 0; ft = 0; wt = '0;
                end else begin
                    cf = fc - 1; ft = dur[cf]; wt = 32'(tot);
                end
            end
            default: ;
        endcase
        s.frame = fas_pkg::IDX_W'(cf);
        s.finished = done;
        s.waiting = wst;
        s.loops = 16'(lc);
        s.elapsed = wt;
        return s;
    endfunction

    // Status word monitor; the receiver cannot stall so every strobe is taken.
    always @(posedge i_clk) begin
        t_status e;
        if (i_rst_n && o_strobe) begin
            if (expected_status_q.size() == 0) begin
                $error("status word with no prediction pending");
                fail_count++;
            end else begin
                e = expected_status_q.pop_front();
                if (o_frame !== e.frame) begin
                    $error("frame: expected %0d actual %0d", e.frame, o_frame);
                    fail_count++;
                end
                if (o_finished !== e.finished) begin
                    $error("finished: expected %0d actual %0d", e.finished, o_finished);
                    fail_count++;
                end
                if (o_waiting !== e.waiting) begin
                    $error("waiting: expected %0d actual %0d", e.waiting, o_waiting);
                    fail_count++;
                end
                if (o_loops_done !== e.loops) begin
                    $error("loops_done: expected %0d actual %0d", e.loops, o_loops_done);
                    fail_count++;
                end
                if (o_elapsed !== e.elapsed) begin
                    $error("elapsed: expected %0d actual %0d", e.elapsed, o_elapsed);
                    fail_count++;
                end
                if (o_error !== e.err) begin
                    $error("error: expected %0d actual %0d", e.err, o_error);
                    fail_count++;
                end
            end
        end
    end

    task automatic send_command(logic [fas_pkg::MODE_W-1:0] mode,
                                logic [fas_pkg::IDX_W-1:0] idx,
                                logic [fas_pkg::TV_W-1:0] tv, logic wreq);
        i_mode <= mode;
        i_frame_index <= idx;
        i_time_value <= tv;
        i_wait_after_restart <= wreq;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        expected_status_q.push_back(advance_sequencer(mode, idx, tv, wreq));
        if (idle_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        @(posedge i_clk);
        while (expected_status_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_register(logic [fas_pkg::CFG_IDX_W-1:0] idx,
                                  logic [fas_pkg::CFG_DATA_W-1:0] data);
        i_cfg_index <= idx;
        i_cfg_data <= data;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        apply_register(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(int frames, bit back, bit looping, bit playing, int hold);
        wait_idle();
        write_register(fas_pkg::CFG_FRAME_COUNT, fas_pkg::CFG_DATA_W'(frames));
        write_register(fas_pkg::CFG_REVERSE, fas_pkg::CFG_DATA_W'(back));
        write_register(fas_pkg::CFG_LOOP_ENABLE, fas_pkg::CFG_DATA_W'(looping));
        write_register(fas_pkg::CFG_PLAY_ENABLE, fas_pkg::CFG_DATA_W'(playing));
        write_register(fas_pkg::CFG_LOOP_WAIT, fas_pkg::CFG_DATA_W'(hold));
    endtask

    // Mostly short ticks against short durations so that frames, wraps and
    // holds happen often; a few words carry full-range values.
    task automatic random_traffic(int count, int dur_max);
        int                         pick;
        logic [fas_pkg::MODE_W-1:0] mode;
        logic [fas_pkg::TV_W-1:0]   tv;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) mode = fas_pkg::MODE_TICK;
            else if (pick < 72) mode = fas_pkg::MODE_WRITE;
            else if (pick < 75) mode = fas_pkg::MODE_FILL;
            else if (pick < 86) mode = fas_pkg::MODE_SEEK;
            else if (pick < 96) mode = fas_pkg::MODE_RESTART;
            else mode = fas_pkg::MODE_W'($urandom_range(5, 7));
            if ($urandom_range(0, 19) == 0) tv = fas_pkg::TV_W'($urandom());
            else if (mode == fas_pkg::MODE_TICK) tv = fas_pkg::TV_W'($urandom_range(0, 3 * dur_max));
            else tv = fas_pkg::TV_W'($urandom_range(0, dur_max));
            send_command(mode, fas_pkg::IDX_W'($urandom_range(0, 63)), tv, 1'($urandom()));
        end
    endtask

    task automatic test_directed();
        send_command(fas_pkg::MODE_TICK, '0, '0, 1'b0);
        send_command(fas_pkg::MODE_TICK, '0, 24'd250, 1'b0);
        send_command(fas_pkg::MODE_WRITE, 6'd63, 24'd5, 1'b0);
        send_command(fas_pkg::MODE_WRITE, '0, '0, 1'b0);
        send_command(fas_pkg::MODE_FILL, '0, '0, 1'b0);
        send_command(fas_pkg::MODE_SEEK, 6'd63, '0, 1'b0);
        send_command(fas_pkg::MODE_SEEK, '0, '0, 1'b0);
        send_command(fas_pkg::MODE_RESTART, '0, '0, 1'b1);
        send_command(fas_pkg::MODE_TICK, '0, 24'd7, 1'b0);
        send_command(fas_pkg::MODE_RESTART, '0, '0, 1'b0);
        send_command(fas_pkg::MODE_W'(5), 6'd63, 24'hFFFFFF, 1'b1);
        send_command(fas_pkg::MODE_W'(6), '0, '0, 1'b0);
        send_command(fas_pkg::MODE_W'(7), '0, '0, 1'b0);
        send_command(fas_pkg::MODE_WRITE, '0, 24'hFFFFFF, 1'b0);
        send_command(fas_pkg::MODE_TICK, '0, 24'hFFFFFF, 1'b0);
        send_command(fas_pkg::MODE_FILL, '0, 24'd3, 1'b0);
        send_command(fas_pkg::MODE_TICK, '0, 24'hFFFFFF, 1'b0);
        // Frame count saturates at both ends.
        wait_idle();
        write_register(fas_pkg::CFG_FRAME_COUNT, 24'd0);
        write_register(fas_pkg::CFG_FRAME_COUNT, 24'd127);
        send_command(fas_pkg::MODE_SEEK, 6'd63, '0, 1'b0);
        send_command(fas_pkg::MODE_TICK, '0, 24'd6500, 1'b0);
    endtask

    task automatic test_forward_loops();
        configure(8, 0, 1, 1, 0);
        random_traffic(170, 40);
    endtask

    task automatic test_forward_hold();
        configure(5, 0, 1, 1, 60);
        random_traffic(170, 30);
    endtask

    task automatic test_reverse_hold();
        configure(7, 1, 1, 1, 25);
        random_traffic(170, 30);
    endtask

    task automatic test_one_shot();
        configure(13, 0, 0, 1, 0);
        random_traffic(120, 30);
        configure(6, 1, 0, 1, 10);
        random_traffic(120, 30);
    endtask

    task automatic test_paused_and_max_hold();
        configure(64, 1, 1, 0, 16777215);
        random_traffic(60, 50);
        wait_idle();
        write_register(fas_pkg::CFG_PLAY_ENABLE, 24'd1);
        random_traffic(100, 50);
    endtask

    task automatic test_no_idle_tail();
        configure(3, 0, 1, 1, 9);
        idle_on = 1'b0;
        random_traffic(100, 20);
        configure(4, 1, 1, 1, 0);
        random_traffic(100, 20);
    endtask

    initial begin
        reset_sequencer();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_forward_loops();
        test_forward_hold();
        test_reverse_hold();
        test_one_shot();
        test_paused_and_max_hold();
        test_no_idle_tail();
        wait_idle();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #100ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule

@@ sim.f @@
design/fas_pkg.sv
design/fas_ram.sv
design/fas_div.sv
design/fas_fifo.sv
design/fas_front.sv
design/fas_back.sv
design/frame_animation_sequencer.sv
tb/tb_frame_animation_sequencer.sv
